@@ design/ring_pointer_page_tracker_defines.svh @@
// Assertion macros used by the tracker design file.
`ifndef RING_POINTER_PAGE_TRACKER_DEFINES_SVH
`define RING_POINTER_PAGE_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
// Implication checked on every rising clock edge outside reset.
`define RPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define RPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RPT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RPT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/rpt_pkg.sv @@
`default_nettype none
package rpt_pkg;
    localparam int unsigned EPOCH_PAGES = 4;
    localparam int unsigned EPOCH_BITS  = 2;
    localparam int unsigned EXPIRE_GAP  = 2;
    localparam logic [EPOCH_BITS-1:0] WRAP_CODE = 2'd3;
    localparam int unsigned DIV_BITS = 33;

    typedef enum logic [1:0] {
        OP_UPDATE  = 2'd0,
        OP_COMPUTE = 2'd1,
        OP_CHECK   = 2'd2,
        OP_COMPARE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_POINTER_RANGE = 2'd0,
        REG_PAGE_LENGTH   = 2'd1,
        REG_MAX_MESSAGES  = 2'd2
    } reg_index_t;

    localparam logic [1:0] AVAIL_OK      = 2'd0;
    localparam logic [1:0] AVAIL_EXPIRED = 2'd1;
    localparam logic [1:0] AVAIL_FUTURE  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic        add_one;
        logic [28:0] remove_count;
        logic [29:0] pointer_a;
        logic [31:0] page_a;
        logic [31:0] increment;
        logic [29:0] pointer_b;
    } in_item_t;

    typedef struct packed {
        logic [29:0] new_pointer;
        logic [31:0] new_page;
        logic [28:0] message_count;
        logic [1:0]  availability;
        logic [1:0]  order;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_item_t;

    // Start request to the shared divider, and its answer.
    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [DIV_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quotient;
        logic [DIV_BITS-1:0] remainder;
    } div_rsp_t;

    // Page correction against the page index of the pointer.
    function automatic logic [31:0] correct_page(input logic [EPOCH_BITS-1:0] np,
                                                 input logic [31:0] base_page);
        logic [EPOCH_BITS-1:0] nc;
        nc = np - base_page[EPOCH_BITS-1:0];
        if (nc == WRAP_CODE)
            return base_page - 32'd1;
        return base_page + {{(32-EPOCH_BITS){1'b0}}, nc};
    endfunction
endpackage
`default_nettype wire

@@ design/rpt_stream_if.sv @@
`default_nettype none
interface rpt_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/rpt_divider.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rpt_divider
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  rpt_pkg::div_req_t req,
    output rpt_pkg::div_rsp_t rsp
);
    import rpt_pkg::*;

    logic [DIV_BITS-1:0] quot_reg, quot_next;
    logic [DIV_BITS-1:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0] dsr_reg, dsr_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIV_BITS:0]   trial;

    // Load on start, else one shift and subtract step while busy.
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[DIV_BITS-1]} - {1'b0, dsr_reg};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 6'(DIV_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_BITS])
            begin
                rem_next  = trial[DIV_BITS-1:0];
                quot_next = {quot_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[DIV_BITS-2:0], quot_reg[DIV_BITS-1]};
                quot_next = {quot_reg[DIV_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;
endmodule
`default_nettype wire

@@ design/ring_pointer_page_tracker.sv @@
// Compare items go straight to execution; check and update without an added message pass
// once through the shared 33-step divider, compute and update with an added message three
// times. One item at a time: a new item is taken only in idle, after the result of the
// last one has been transferred.
// Reset (rst_n, asynchronous, active low) clears the count, write pointer and page epoch
// and loads pointer_range 1024, page_length 256 and max_messages 64.
`default_nettype none
module ring_pointer_page_tracker
(
    input wire logic clk,
    input wire logic rst_n,
    rpt_stream_if.sink   in_ch,
    rpt_stream_if.source out_ch,
    rpt_stream_if.sink   cfg_ch
);
    import rpt_pkg::*;
    `include "ring_pointer_page_tracker_defines.svh"

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIV1  = 8'b0000_0010,
        ST_DIV2  = 8'b0000_0100,
        ST_DIV3  = 8'b0000_1000,
        ST_WAIT  = 8'b0001_0000,
        ST_EXEC  = 8'b0010_0000,
        ST_OUT   = 8'b0100_0000,
        ST_STEP  = 8'b1000_0000
    } state_t;

    state_t    state_reg, state_next;
    in_item_t  item_reg, item_next;
    out_item_t res_reg, res_next;
    logic [1:0] phase_reg, phase_next;
    logic [30:0] range_reg, range_next;
    logic [28:0] plen_reg, plen_next;
    logic [28:0] maxm_reg, maxm_next;
    logic [28:0] count_reg, count_next;
    logic [29:0] wptr_reg, wptr_next;
    logic [31:0] epoch_reg, epoch_next;
    logic [DIV_BITS-1:0] q0_reg, q0_next, r0_reg, r0_next;
    logic [DIV_BITS-1:0] r1_reg, r1_next;
    logic [DIV_BITS-1:0] ta_reg, ta_next;
    logic        tneg_reg, tneg_next;
    logic        npneg_reg, npneg_next;
    div_req_t    dreq;
    div_rsp_t    drsp;
    logic [31:0] cfg_val;
    logic [31:0] cur_page;
    logic signed [33:0] inc_s, off_s, t_s, np_s;

    rpt_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign cfg_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = (state_reg == ST_OUT);
    assign out_ch.data  = res_reg;
    assign cfg_val      = cfg_ch.data.data;
    assign cur_page     = correct_page(q0_reg[EPOCH_BITS-1:0], epoch_reg);
    assign inc_s        = 34'(signed'(item_reg.increment));
    assign off_s        = $signed({1'b0, r0_reg});

    // Sequencer: any divisions go through the shared unit, then one execution step.
    always_comb
    begin
        logic [31:0] pg;
        logic [29:0] ptr;
        logic signed [31:0] cs, ps;
        logic signed [31:0] mx, mn, p;
        logic signed [30:0] n;
        state_next = state_reg;
        item_next  = item_reg;
        res_next   = res_reg;
        phase_next = phase_reg;
        range_next = range_reg;
        plen_next  = plen_reg;
        maxm_next  = maxm_reg;
        count_next = count_reg;
        wptr_next  = wptr_reg;
        epoch_next = epoch_reg;
        q0_next    = q0_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        ta_next    = ta_reg;
        tneg_next  = tneg_reg;
        npneg_next = npneg_reg;
        dreq       = '0;
        t_s        = '0;
        np_s       = '0;
        pg = '0; ptr = '0; cs = '0; ps = '0; mx = '0; mn = '0; p = '0; n = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_ch.valid)
                begin
                    unique case (cfg_ch.data.index)
                        REG_POINTER_RANGE:
                            range_next = (cfg_val[30:0] < 31'd4) ? 31'd4 :
                                (cfg_val[30:0] > 31'h4000_0000) ? 31'h4000_0000 :
                                cfg_val[30:0];
                        REG_PAGE_LENGTH:
                            plen_next = (cfg_val[28:0] == 29'd0) ? 29'd1 :
                                (cfg_val[28:0] > 29'h1000_0000) ? 29'h1000_0000 :
                                cfg_val[28:0];
                        REG_MAX_MESSAGES:
                            maxm_next = (cfg_val[28:0] == 29'd0) ? 29'd1 :
                                (cfg_val[28:0] > 29'h1000_0000) ? 29'h1000_0000 :
                                cfg_val[28:0];
                        default: ;
                    endcase
                end
                else if (in_ch.valid)
                begin
                    item_next  = in_ch.data;
                    phase_next = 2'd0;
                    if (in_ch.data.op == OP_COMPARE)
                        state_next = ST_EXEC;
                    else
                        state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                // Page index of the write pointer, or offset of pointer_a in its page.
                dreq.start    = 1'b1;
                dreq.dividend = (item_reg.op == OP_COMPUTE) ?
                    DIV_BITS'(item_reg.pointer_a) : DIV_BITS'(wptr_reg);
                dreq.divisor  = DIV_BITS'(plen_reg);
                phase_next    = 2'd0;
                state_next    = ST_WAIT;
            end
            ST_DIV2:
            begin
                // Wrapped pointer: pointer_a plus increment, or write pointer plus one,
                // reduced modulo the range. A negative sum is divided by its magnitude.
                if (item_reg.op == OP_COMPUTE)
                    np_s = $signed({4'b0, item_reg.pointer_a}) + inc_s;
                else
                    np_s = $signed({4'b0, wptr_reg}) + 34'sd1;
                npneg_next    = np_s[33];
                dreq.start    = 1'b1;
                dreq.dividend = np_s[33] ? DIV_BITS'(-np_s) : DIV_BITS'(np_s);
                dreq.divisor  = DIV_BITS'(range_reg);
                phase_next    = 2'd1;
                state_next    = ST_WAIT;
            end
            ST_DIV3:
            begin
                // Page steps beyond the first crossing.
                if (!inc_s[33])
                    t_s = inc_s - ($signed({5'b0, plen_reg}) - off_s);
                else
                    t_s = -inc_s - off_s - 34'sd1;
                tneg_next = t_s[33];
                dreq.start    = 1'b1;
                dreq.dividend = t_s[33] ? '0 : DIV_BITS'(t_s);
                dreq.divisor  = DIV_BITS'(plen_reg);
                phase_next    = 2'd2;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (drsp.done)
                begin
                    unique case (phase_reg)
                        2'd0:
                        begin
                            q0_next = drsp.quotient;
                            r0_next = drsp.remainder;
                            state_next = (item_reg.op == OP_COMPUTE) ? ST_DIV2 :
                                (item_reg.op == OP_UPDATE && item_reg.add_one) ?
                                ST_DIV2 : ST_EXEC;
                        end
                        2'd1:
                        begin
                            // A negative sum leaves the range minus its remainder.
                            if (npneg_reg && drsp.remainder != '0)
                                r1_next = DIV_BITS'(range_reg) - drsp.remainder;
                            else
                                r1_next = drsp.remainder;
                            state_next = (item_reg.op == OP_COMPUTE) ? ST_DIV3 : ST_STEP;
                        end
                        2'd2:
                        begin
                            ta_next = drsp.quotient;
                            state_next = ST_EXEC;
                        end
                        default:
                        begin
                            r1_next = drsp.remainder;
                            state_next = ST_EXEC;
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                // Page offset of the new write pointer after adding a message.
                ptr = r1_reg[29:0];
                dreq.start    = 1'b1;
                dreq.dividend = DIV_BITS'(ptr);
                dreq.divisor  = DIV_BITS'(plen_reg);
                r0_next       = DIV_BITS'(ptr);
                phase_next    = 2'd3;
                state_next    = ST_WAIT;
            end
            ST_EXEC:
            begin
                res_next = '0;
                case (item_reg.op)
                    OP_UPDATE:
                    begin
                        n = 31'(count_reg) + 31'(item_reg.add_one)
                            - 31'(item_reg.remove_count);
                        if (n[30])
                            n = '0;
                        else if (n > $signed({2'b0, maxm_reg}))
                            n = $signed({2'b0, maxm_reg});
                        count_next = n[28:0];
                        if (item_reg.add_one)
                        begin
                            pg = cur_page + ((r1_reg == '0) ? 32'd1 : 32'd0);
                            epoch_next = pg;
                            wptr_next  = r0_reg[29:0];
                        end
                        else
                            pg = epoch_reg;
                        res_next.new_pointer = item_reg.add_one ? r0_reg[29:0] : wptr_reg;
                        res_next.new_page    = pg;
                        res_next.message_count = n[28:0];
                    end
                    OP_COMPUTE:
                    begin
                        res_next.new_pointer = r1_reg[29:0];
                        if (tneg_reg)
                            res_next.new_page = item_reg.page_a;
                        else if (!inc_s[33])
                            res_next.new_page = item_reg.page_a + 32'd1 + ta_reg[31:0];
                        else
                            res_next.new_page = item_reg.page_a - 32'd1 - ta_reg[31:0];
                        res_next.message_count = count_reg;
                    end
                    OP_CHECK:
                    begin
                        cs = $signed(cur_page);
                        ps = $signed(item_reg.page_a);
                        p  = $signed({2'b0, item_reg.pointer_a});
                        res_next.message_count = count_reg;
                        if (ps > cs || (ps == cs && p >= $signed({2'b0, wptr_reg})))
                            res_next.availability = AVAIL_FUTURE;
                        else if (34'(cs) - 34'(ps) > 34'(EXPIRE_GAP))
                            res_next.availability = AVAIL_EXPIRED;
                        else
                        begin
                            mx = $signed({2'b0, wptr_reg}) - 32'sd1;
                            if (mx < 0)
                                mx = mx + $signed({1'b0, range_reg});
                            mn = mx - $signed({3'b0, count_reg}) + 32'sd1;
                            if (mn < 0)
                            begin
                                if (p <= mx)
                                    p = p + $signed({1'b0, range_reg});
                                mx = mx + $signed({1'b0, range_reg});
                                mn = mx - $signed({3'b0, count_reg}) + 32'sd1;
                            end
                            res_next.availability = (p <= mx && p >= mn) ?
                                AVAIL_OK : AVAIL_EXPIRED;
                        end
                    end
                    default:
                    begin
                        res_next.message_count = count_reg;
                        if (item_reg.pointer_a != item_reg.pointer_b)
                        begin
                            if ((item_reg.pointer_a > item_reg.pointer_b) ==
                                ((item_reg.pointer_a > item_reg.pointer_b ?
                                  item_reg.pointer_a - item_reg.pointer_b :
                                  item_reg.pointer_b - item_reg.pointer_a) <
                                 {maxm_reg, 1'b0}))
                                res_next.order = 2'b01;
                            else
                                res_next.order = 2'b11;
                        end
                    end
                endcase
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control and bookkeeping state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 2'd0;
            range_reg <= 31'd1024;
            plen_reg  <= 29'd256;
            maxm_reg  <= 29'd64;
            count_reg <= '0;
            wptr_reg  <= '0;
            epoch_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            range_reg <= range_next;
            plen_reg  <= plen_next;
            maxm_reg  <= maxm_next;
            count_reg <= count_next;
            wptr_reg  <= wptr_next;
            epoch_reg <= epoch_next;
        end
    end

    // Item and intermediate payload.
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        res_reg   <= res_next;
        q0_reg    <= q0_next;
        r0_reg    <= r0_next;
        r1_reg    <= r1_next;
        ta_reg    <= ta_next;
        tneg_reg  <= tneg_next;
        npneg_reg <= npneg_next;
    end

    `RPT_ASSERT_IMP(a_one_side, clk, rst_n, out_ch.valid, !in_ch.ready && !cfg_ch.ready)
    `RPT_ASSERT_IMP(a_div_idle, clk, rst_n, dreq.start, state_reg != ST_WAIT)
    `RPT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(res_reg))
    `RPT_ASSERT_IMP(a_range_ok, clk, rst_n, 1'b1, range_reg >= 31'd4)
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
module tb_top;
    import rpt_pkg::*;

    logic clk;
    logic rst_n;

    rpt_stream_if #(.T(in_item_t))  in_ch();
    rpt_stream_if #(.T(out_item_t)) out_ch();
    rpt_stream_if #(.T(cfg_item_t)) cfg_ch();

    ring_pointer_page_tracker dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Shadow copy of the tracker state and its registers.
    longint unsigned range_q;
    longint unsigned plen_q;
    longint unsigned maxmsg_q;
    longint unsigned count_q;
    longint unsigned wptr_q;
    logic [31:0]     epoch_q;

    out_item_t expected_results[$];
    int        errors;
    int        items_sent;
    int        op_seen[4];
    int        configs_done;
    bit        idle_on;
    int        out_stall;

    // Clock with a 12-unit period.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Page number corrected against the page index of its pointer.
    function automatic logic [31:0] fix_page(input longint unsigned ptr,
                                             input logic [31:0] base);
        logic [1:0] np;
        logic [1:0] nc;
        np = 2'((ptr / plen_q) & 3);
        nc = np - base[1:0];
        if (nc == WRAP_CODE)
            return base - 32'd1;
        return base + {30'd0, nc};
    endfunction

    // Register write as the block sees it, with saturation.
    function automatic void apply_reg(input reg_index_t idx, input logic [31:0] value);
        longint unsigned v;
        case (idx)
            REG_POINTER_RANGE:
            begin
                v = value & 32'h7FFF_FFFF;
                range_q = (v < 4) ? 4 : (v > 64'd1073741824) ? 64'd1073741824 : v;
            end
            REG_PAGE_LENGTH:
            begin
                v = value & 32'h1FFF_FFFF;
                plen_q = (v < 1) ? 1 : (v > 64'd268435456) ? 64'd268435456 : v;
            end
            REG_MAX_MESSAGES:
            begin
                v = value & 32'h1FFF_FFFF;
                maxmsg_q = (v < 1) ? 1 : (v > 64'd268435456) ? 64'd268435456 : v;
            end
            default: ;
        endcase
    endfunction

    // Expected result of one item; advances the shadow state.
    function automatic out_item_t track_item(input in_item_t it);
        out_item_t       r;
        longint unsigned ptr;
        logic [31:0]     page;
        longint          n, rr, ps, off, np, t, inc, pt, cur, pg, p, mx, mn, d;
        r   = '0;
        inc = longint'($signed(it.increment));
        case (op_t'(it.op))
            OP_UPDATE:
            begin
                ptr  = wptr_q;
                page = fix_page(ptr, epoch_q);
                if (it.add_one)
                begin
                    ptr = (ptr + 1) % range_q;
                    if (ptr % plen_q == 0)
                        page = page + 32'd1;
                    epoch_q = page;
                end
                n = longint'(count_q) + longint'(it.add_one) - longint'(it.remove_count);
                if (n < 0)
                    n = 0;
                if (n > longint'(maxmsg_q))
                    n = longint'(maxmsg_q);
                count_q = n;
                wptr_q  = ptr;
                r.new_pointer = 30'(wptr_q);
                r.new_page    = epoch_q;
            end
            OP_COMPUTE:
            begin
                rr  = longint'(range_q);
                ps  = longint'(plen_q);
                off = longint'(it.pointer_a) % ps;
                np  = (longint'(it.pointer_a) + inc) % rr;
                if (np < 0)
                    np += rr;
                r.new_pointer = 30'(np);
                r.new_page    = it.page_a;
                if (inc >= 0)
                begin
                    t = inc - (ps - off);
                    if (t >= 0)
                        r.new_page = it.page_a + 32'(1 + t / ps);
                end
                else
                begin
                    t = -inc - off - 1;
                    if (t >= 0)
                        r.new_page = it.page_a - 32'(1 + t / ps);
                end
            end
            OP_CHECK:
            begin
                pt  = longint'(wptr_q);
                cur = longint'($signed(fix_page(wptr_q, epoch_q)));
                pg  = longint'($signed(it.page_a));
                p   = longint'(it.pointer_a);
                if (pg > cur || (pg >= cur && p >= pt))
                    r.availability = AVAIL_FUTURE;
                else if (cur - pg > EXPIRE_GAP)
                    r.availability = AVAIL_EXPIRED;
                else
                begin
                    mx = pt - 1;
                    if (mx < 0)
                        mx += longint'(range_q);
                    mn = mx - longint'(count_q) + 1;
                    if (mn < 0)
                    begin
                        if (p <= mx)
                            p += longint'(range_q);
                        mx += longint'(range_q);
                        mn = mx - longint'(count_q) + 1;
                    end
                    r.availability = (p <= mx && p >= mn) ? AVAIL_OK : AVAIL_EXPIRED;
                end
            end
            default:
            begin
                if (it.pointer_a != it.pointer_b)
                begin
                    d = (it.pointer_a > it.pointer_b) ? it.pointer_a - it.pointer_b
                                                      : it.pointer_b - it.pointer_a;
                    if ((d < 2 * longint'(maxmsg_q)) == (it.pointer_a > it.pointer_b))
                        r.order = 2'b01;
                    else
                        r.order = 2'b11;
                end
            end
        endcase
        r.message_count = 29'(count_q);
        return r;
    endfunction

    // Send one item, with an optional idle burst first; valid stays high afterwards.
    task automatic send_item(input in_item_t it);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_results.push_back(track_item(it));
        items_sent++;
        op_seen[it.op]++;
    endtask

    // Lower valid and wait until every expected result has come, then let the block settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    // Register write; valid stays high for back-to-back writes until cfg_done.
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_reg(idx, value);
        configs_done++;
    endtask

    task automatic cfg_done();
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic in_item_t mk(input op_t op, input logic add, input logic [28:0] rm,
                                    input logic [29:0] pa, input logic [31:0] pg,
                                    input logic [31:0] inc, input logic [29:0] pb);
        in_item_t it;
        it = '{op: op, add_one: add, remove_count: rm, pointer_a: pa, page_a: pg,
               increment: inc, pointer_b: pb};
        return it;
    endfunction

    // Random item, biased towards values near the current pointer and page.
    function automatic in_item_t rand_item();
        in_item_t it;
        int       sel;
        it.op      = 2'($urandom_range(0, 3));
        it.add_one = ($urandom_range(0, 3) != 0);
        sel        = $urandom_range(0, 9);
        it.remove_count = (sel == 0) ? 29'($urandom_range(0, 268435456))
                        : (sel < 4) ? 29'($urandom_range(0, 3)) : 29'd0;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            it.pointer_a = 30'((wptr_q + range_q - $urandom_range(0, 8)) % range_q);
        else if (sel < 8)
            it.pointer_a = 30'($urandom % range_q);
        else
            it.pointer_a = 30'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 7)
            it.page_a = fix_page(it.pointer_a, epoch_q) + 32'($urandom_range(0, 7)) - 32'd4;
        else
            it.page_a = $urandom;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            it.increment = 32'($urandom_range(0, 40)) - 32'd20;
        else if (sel < 8)
            it.increment = 32'($urandom % (2 * range_q)) - 32'(range_q);
        else
            it.increment = 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
        sel = $urandom_range(0, 3);
        if (sel == 0)
            it.pointer_b = it.pointer_a;
        else if (sel == 1)
            it.pointer_b = 30'(it.pointer_a + 2 * maxmsg_q + $urandom_range(0, 2) - 1);
        else
            it.pointer_b = 30'($urandom);
        return it;
    endfunction

    // Random register setting; page length kept within a quarter of the range.
    task automatic random_config();
        logic [31:0] rng;
        case ($urandom_range(0, 3))
            0: rng = $urandom_range(4, 64);
            1: rng = $urandom_range(64, 4096);
            2: rng = $urandom_range(4096, 32'h4000_0000);
            default: rng = $urandom;
        endcase
        write_reg(REG_POINTER_RANGE, rng);
        write_reg(REG_PAGE_LENGTH, $urandom_range(1, (range_q / 4 > 0) ? range_q / 4 : 1));
        write_reg(REG_MAX_MESSAGES, ($urandom_range(0, 3) == 0) ? $urandom
                                                                  : $urandom_range(1, 40));
        cfg_done();
    endtask

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer: %p", out_ch.data);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (out_ch.data.new_pointer !== e.new_pointer)
                begin
                    $error("new_pointer: expected %0d, actual %0d", e.new_pointer,
                           out_ch.data.new_pointer);
                    errors++;
                end
                if (out_ch.data.new_page !== e.new_page)
                begin
                    $error("new_page: expected %0d, actual %0d", $signed(e.new_page),
                           $signed(out_ch.data.new_page));
                    errors++;
                end
                if (out_ch.data.message_count !== e.message_count)
                begin
                    $error("message_count: expected %0d, actual %0d", e.message_count,
                           out_ch.data.message_count);
                    errors++;
                end
                if (out_ch.data.availability !== e.availability)
                begin
                    $error("availability: expected %0d, actual %0d", e.availability,
                           out_ch.data.availability);
                    errors++;
                end
                if (out_ch.data.order !== e.order)
                begin
                    $error("order: expected %0d, actual %0d", $signed(e.order),
                           $signed(out_ch.data.order));
                    errors++;
                end
            end
        end
    end

    // Receiver stalls in random bursts.
    always @(posedge clk)
    begin
        if (out_stall > 0)
        begin
            out_stall--;
            out_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_stall = $urandom_range(0, 8);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // Field extremes, every operation and the special cases.
    task automatic test_directed();
        send_item(mk(OP_CHECK, 1'b0, '0, 30'd0, 32'd0, 32'd0, 30'd0));
        send_item(mk(OP_UPDATE, 1'b0, 29'd0, 30'd0, 32'd0, 32'd0, 30'd0));
        for (int i = 0; i < 3; i++)
            send_item(mk(OP_UPDATE, 1'b1, 29'd0, '1, '1, '1, '1));
        send_item(mk(OP_CHECK, 1'b0, '0, 30'd1, 32'd0, 32'd0, 30'd0));
        send_item(mk(OP_CHECK, 1'b0, '0, 30'd3, 32'd0, 32'd0, 30'd0));
        send_item(mk(OP_CHECK, 1'b0, '0, 30'd1, 32'h8000_0000, 32'd0, 30'd0));
        send_item(mk(OP_CHECK, 1'b0, '0, 30'd1, 32'h7FFF_FFFF, 32'd0, 30'd0));
        send_item(mk(OP_CHECK, 1'b0, '0, 30'd1020, 32'hFFFF_FFFF, 32'd0, 30'd0));
        send_item(mk(OP_UPDATE, 1'b1, 29'h1000_0000, 30'd0, 32'd0, 32'd0, 30'd0));
        send_item(mk(OP_UPDATE, 1'b0, 29'h1FFF_FFFF, 30'd0, 32'd0, 32'd0, 30'd0));
        send_item(mk(OP_COMPUTE, 1'b0, '0, 30'd255, 32'h7FFF_FFFF, 32'h4000_0000, 30'd0));
        send_item(mk(OP_COMPUTE, 1'b0, '0, 30'd0, 32'h8000_0000, 32'hC000_0000, 30'd0));
        send_item(mk(OP_COMPUTE, 1'b0, '0, 30'd256, 32'd5, 32'hFFFF_FFFF, 30'd0));
        send_item(mk(OP_COMPUTE, 1'b0, '0, 30'h3FFF_FFFF, 32'd0, 32'd1, 30'd0));
        send_item(mk(OP_COMPUTE, 1'b0, '0, 30'd10, 32'd3, 32'd0, 30'd0));
        send_item(mk(OP_COMPARE, 1'b0, '0, 30'd7, 32'd0, 32'd0, 30'd7));
        send_item(mk(OP_COMPARE, 1'b0, '0, 30'd10, 32'd0, 32'd0, 30'd5));
        send_item(mk(OP_COMPARE, 1'b0, '0, 30'd5, 32'd0, 32'd0, 30'd10));
        send_item(mk(OP_COMPARE, 1'b0, '0, 30'd200, 32'd0, 32'd0, 30'd72));
        send_item(mk(OP_COMPARE, 1'b0, '0, 30'd0, 32'd0, 32'd0, 30'h3FFF_FFFF));
        drain();
    endtask

    // Register extremes, including saturation of out-of-range writes.
    task automatic test_register_extremes();
        write_reg(REG_POINTER_RANGE, 32'd0);
        write_reg(REG_PAGE_LENGTH, 32'd0);
        write_reg(REG_MAX_MESSAGES, 32'd0);
        cfg_done();
        for (int i = 0; i < 40; i++)
            send_item(rand_item());
        drain();
        write_reg(REG_POINTER_RANGE, 32'hFFFF_FFFF);
        write_reg(REG_PAGE_LENGTH, 32'hFFFF_FFFF);
        write_reg(REG_MAX_MESSAGES, 32'hFFFF_FFFF);
        cfg_done();
        for (int i = 0; i < 40; i++)
            send_item(rand_item());
        drain();
        write_reg(REG_POINTER_RANGE, 32'h4000_0000);
        write_reg(REG_PAGE_LENGTH, 32'h1000_0000);
        write_reg(REG_MAX_MESSAGES, 32'h1000_0000);
        cfg_done();
        for (int i = 0; i < 40; i++)
            send_item(rand_item());
        drain();
    endtask

    // Random items over a series of register settings.
    task automatic test_random(input int phases, input int per_phase);
        for (int ph = 0; ph < phases; ph++)
        begin
            random_config();
            for (int i = 0; i < per_phase; i++)
                send_item(rand_item());
            drain();
        end
    endtask

    // After every tenth item the sender holds off until the result queue is empty before going on.
    task automatic test_hold_off();
        for (int i = 0; i < 30; i++)
        begin
            send_item(rand_item());
            if (i % 10 == 9)
            begin
                in_ch.valid <= 1'b0;
                while (expected_results.size() != 0)
                    @(posedge clk);
            end
        end
        drain();
    endtask

    initial
    begin
        errors       = 0;
        items_sent   = 0;
        configs_done = 0;
        op_seen      = '{default: 0};
        idle_on      = 1'b1;
        out_stall    = 0;
        range_q  = 1024;
        plen_q   = 256;
        maxmsg_q = 64;
        count_q  = 0;
        wptr_q   = 0;
        epoch_q  = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;
        rst_n        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        test_hold_off();
        test_random(10, 100);
        idle_on = 1'b0;
        test_random(1, 80);

        $display("Covered %0d items (update %0d, compute %0d, check %0d, compare %0d)",
                 items_sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("over %0d register writes, with idle bursts on both channels.",
                 configs_done);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Overall time limit.
    initial
    begin
        #60000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire

@@ ring_pointer_page_tracker.f @@
+incdir+design
design/rpt_pkg.sv
design/rpt_stream_if.sv
design/rpt_divider.sv
design/ring_pointer_page_tracker.sv
test/tb_top.sv
